[rtl/ccbd_pkg.sv]
// Shared constants, state type and colour helpers of the centre-crop box downscaler.
package ccbd_pkg;

  localparam int OUT_SIDE_DEF = 96;
  localparam int MAX_SIDE_DEF = 4096;
  localparam int CFG_W        = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CH_W         = 8;
  localparam int COORD_W      = 7;
  localparam int LANES        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUANT  = 2'd2;

  typedef enum logic [2:0] {
    ST_GEO_GO,
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_SEND
  } ccbd_state_t;

  function automatic logic [CH_W-1:0] quant5(input logic [CH_W-1:0] v);
    return {v[7:3], v[7:5]};
  endfunction

  function automatic logic [CH_W-1:0] quant6(input logic [CH_W-1:0] v);
    return {v[7:2], v[7:6]};
  endfunction

endpackage

[rtl/ccbd_div.sv]
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
module ccbd_div
  import ccbd_pkg::*;
#(
  parameter int DVD_W = 20,
  parameter int DVS_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend [LANES],
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient [LANES]
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo [LANES];
  logic [DVS_W-1:0] rem [LANES];
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] steps;
  logic             run;

  // track the running division
  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        steps <= CNT_W'(DVD_W);
      end else if (run) begin
        steps <= steps - 1'b1;
        if (steps == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit and trial-subtract on each lane
  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      for (int i = 0; i < LANES; i++) begin
        quo[i] <= dividend[i];
        rem[i] <= '0;
      end
    end else if (run) begin
      for (int i = 0; i < LANES; i++) begin
        if ({rem[i], quo[i][DVD_W-1]} >= {1'b0, dvs}) begin
          rem[i] <= DVS_W'({rem[i], quo[i][DVD_W-1]} - {1'b0, dvs});
          quo[i] <= {quo[i][DVD_W-2:0], 1'b1};
        end else begin
          rem[i] <= {rem[i][DVS_W-2:0], quo[i][DVD_W-1]};
          quo[i] <= {quo[i][DVD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient = quo;

endmodule

[rtl/ccbd_sums.sv]
// Per-column channel sum memory with registered read and per-entry valid bits.
module ccbd_sums
  import ccbd_pkg::*;
#(
  parameter int DEPTH = 96,
  parameter int WORD_W = 60
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     clear,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WORD_W-1:0]        rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WORD_W-1:0]        wr_data
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;
  logic [WORD_W-1:0] rd_q;
  logic              rd_vld;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits: clear wins over a write
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_q   <= mem[rd_addr];
    rd_vld <= valid[rd_addr];
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[rtl/center_crop_box_downscaler.sv]
// Top level of the centre-crop box downscaler: control, geometry and output register.
//
//  channel | signals                          | word
//  --------+----------------------------------+------------------------------------
//  pixels  | s_tvalid s_tready s_tdata        | one RGB888 source pixel
//  results | m_tvalid m_tready m_tdata m_tlast| block mean, grid position; tlast on
//          |                                  | the frame's last block
//  config  | cfg_we cfg_index cfg_data        | width, height, RGB565 enable
//
// A pixel passes a memory read, then an add and write back. A pixel closing a block
// then waits for the one-bit-a-cycle divider (quotient bits, then done) and for the
// send state. After reset and after each config write to width, height or quant
// the geometry is worked out (reciprocal multiply) in ST_GEO_GO, with s_tready low.
// A full output register holds the block in the send state, with s_tready low; reset
// is synchronous and clears all control state.
module center_crop_box_downscaler
  import ccbd_pkg::*;
#(
  parameter int OUT_SIDE        = OUT_SIDE_DEF,
  parameter int MAX_SOURCE_SIDE = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // in_red, in_green, in_blue
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,   // out_red, out_green, out_blue, out_column,
                                          // out_row, zero fill
  output logic                 m_tlast,   // frame_done
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DIM_W   = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int IDX_W   = $clog2(OUT_SIDE);
  localparam int BLK_MAX = MAX_SOURCE_SIDE / OUT_SIDE + 1;
  localparam int SPAN_W  = $clog2(BLK_MAX + 1);
  localparam int CNT_W   = 2 * SPAN_W;
  localparam int SUM_W   = CH_W + CNT_W;
  localparam int N_W     = $clog2(OUT_SIDE + 1);
  localparam int DVS_W   = (CNT_W > N_W) ? CNT_W : N_W;
  localparam int DVD_W   = (SUM_W > DIM_W) ? SUM_W : DIM_W;
  localparam int EW      = (CFG_W > DIM_W) ? CFG_W : DIM_W;
  localparam int GEO_SH  = DIM_W + $clog2(OUT_SIDE);
  localparam int RECIP   = ((1 << GEO_SH) + OUT_SIDE - 1) / OUT_SIDE;
  localparam int PROD_W  = 2 * DIM_W + 2;

  // configuration registers
  logic [CFG_W-1:0] source_width;
  logic [CFG_W-1:0] source_height;
  logic             quantize_565;
  logic             cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                              cfg_index == REG_QUANT);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= CFG_W'(96);
      source_height <= CFG_W'(96);
      quantize_565  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  source_width  <= cfg_data;
        REG_HEIGHT: source_height <= cfg_data;
        REG_QUANT:  quantize_565  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective dimensions and crop geometry
  logic [DIM_W-1:0] eff_w, eff_h, side, x0, y0;

  always_comb begin
    if (source_width == '0) begin
      eff_w = DIM_W'(1);
    end else if (EW'(source_width) > EW'(MAX_SOURCE_SIDE)) begin
      eff_w = DIM_W'(MAX_SOURCE_SIDE);
    end else begin
      eff_w = DIM_W'(source_width);
    end
    if (source_height == '0) begin
      eff_h = DIM_W'(1);
    end else if (EW'(source_height) > EW'(MAX_SOURCE_SIDE)) begin
      eff_h = DIM_W'(MAX_SOURCE_SIDE);
    end else begin
      eff_h = DIM_W'(source_height);
    end
    side = (eff_w < eff_h) ? eff_w : eff_h;
    x0   = (eff_w - side) >> 1;
    y0   = (eff_h - side) >> 1;
  end

  ccbd_state_t state, state_next;

  // position registers
  logic [DIM_W-1:0] col_cnt, row_cnt;
  logic [IDX_W-1:0] band_idx, blk_idx;
  logic [DIM_W-1:0] band_start, band_end, blk_start, blk_end;
  logic [DIM_W-1:0] qc, qr, step_q;
  logic [DVS_W-1:0] rc, rr, step_r;

  // pixel and emitted block
  logic [CH_W-1:0]  pix [LANES];
  logic [IDX_W-1:0] em_col, em_row;
  logic             em_last, em_zero;

  // output register
  logic [CH_W-1:0]  o_ch [LANES];
  logic [IDX_W-1:0] o_col, o_row;
  logic             o_last;

  // memory and divider
  logic [3*SUM_W-1:0] rd_data, wr_data;
  logic               wr_en;
  logic               restart;
  logic               div_start, div_done;
  logic [DVD_W-1:0]   div_dvd [LANES];
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_quo [LANES];

  ccbd_sums #(.DEPTH(OUT_SIDE), .WORD_W(3 * SUM_W)) u_sums (
    .clk(clk), .rst(rst), .clear(restart),
    .rd_addr(blk_idx), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(blk_idx), .wr_data(wr_data)
  );

  ccbd_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_quo)
  );

  // per-pixel decisions in the accumulate cycle
  logic             in_crop, last_blk_col, last_band_row, emit;
  logic             last_col, last_row, blk_wrap, band_wrap;
  logic [SUM_W-1:0] new_sum [LANES];
  logic [CNT_W-1:0] cnt;

  always_comb begin
    in_crop = (side >= DIM_W'(OUT_SIDE)) && (col_cnt >= x0) &&
              ({1'b0, col_cnt} < {1'b0, x0} + {1'b0, side}) && (row_cnt >= y0) &&
              ({1'b0, row_cnt} < {1'b0, y0} + {1'b0, side});
    last_blk_col  = ({1'b0, col_cnt} + 1'b1) >= {1'b0, blk_end};
    last_band_row = ({1'b0, row_cnt} + 1'b1) >= {1'b0, band_end};
    emit      = in_crop && last_blk_col && last_band_row;
    last_col  = ({1'b0, col_cnt} + 1'b1) >= {1'b0, eff_w};
    last_row  = ({1'b0, row_cnt} + 1'b1) >= {1'b0, eff_h};
    blk_wrap  = ({1'b0, blk_idx} + 1'b1) >= (IDX_W + 1)'(OUT_SIDE);
    band_wrap = ({1'b0, band_idx} + 1'b1) >= (IDX_W + 1)'(OUT_SIDE);
    for (int i = 0; i < LANES; i++) begin
      new_sum[i] = rd_data[i*SUM_W +: SUM_W] + SUM_W'(pix[i]);
    end
    cnt = CNT_W'(SPAN_W'(blk_end - blk_start)) * CNT_W'(SPAN_W'(band_end - band_start));
  end

  // grid step: quotient and remainder of side / OUT_SIDE by reciprocal multiply
  logic [PROD_W-1:0] geo_prod;
  logic [DIM_W-1:0]  geo_quo, geo_q;
  logic [DVS_W-1:0]  geo_rem, geo_r;

  always_comb begin
    geo_prod = PROD_W'(side) * PROD_W'(RECIP);
    geo_quo  = DIM_W'(geo_prod >> GEO_SH);
    geo_rem  = DVS_W'(side - geo_quo * DIM_W'(OUT_SIDE));
  end

  assign geo_q = (state == ST_GEO_GO) ? geo_quo : step_q;
  assign geo_r = (state == ST_GEO_GO) ? geo_rem : step_r;

  logic [DVS_W:0]   rc_sum, rr_sum;
  logic             rc_c, rr_c;
  logic [DIM_W-1:0] qc_adv, qr_adv;
  logic [DVS_W-1:0] rc_adv, rr_adv;

  always_comb begin
    rc_sum = {1'b0, rc} + {1'b0, step_r};
    rr_sum = {1'b0, rr} + {1'b0, step_r};
    rc_c   = rc_sum >= (DVS_W + 1)'(OUT_SIDE);
    rr_c   = rr_sum >= (DVS_W + 1)'(OUT_SIDE);
    rc_adv = DVS_W'(rc_c ? rc_sum - (DVS_W + 1)'(OUT_SIDE) : rc_sum);
    rr_adv = DVS_W'(rr_c ? rr_sum - (DVS_W + 1)'(OUT_SIDE) : rr_sum);
    qc_adv = qc + step_q + DIM_W'(rc_c);
    qr_adv = qr + step_q + DIM_W'(rr_c);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_GEO_GO:   state_next = ST_IDLE;
      ST_IDLE:     if (s_tvalid) state_next = ST_ACC;
      ST_ACC:      state_next = emit ? ST_DIV : ST_IDLE;
      ST_DIV:      if (div_done) state_next = ST_SEND;
      ST_SEND:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:     state_next = ST_GEO_GO;
    endcase
    if (cfg_hit) state_next = ST_GEO_GO;
  end

  // outputs of the state machine
  always_comb begin
    s_tready  = (state == ST_IDLE);
    wr_en     = (state == ST_ACC) && in_crop;
    div_start = (state == ST_ACC) && emit;
    restart   = (state == ST_GEO_GO) ||
                ((state == ST_ACC) && last_col && last_row);
    for (int i = 0; i < LANES; i++) begin
      wr_data[i*SUM_W +: SUM_W] = emit ? '0 : new_sum[i];
      div_dvd[i] = DVD_W'(new_sum[i]);
    end
    div_dvs = DVS_W'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_GEO_GO;
    end else begin
      state <= state_next;
    end
  end

  // capture pixel
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < LANES; i++) begin
        pix[i] <= s_tdata[i*CH_W +: CH_W];
      end
    end
  end

  // hold grid step once the geometry is worked out
  always_ff @(posedge clk) begin
    if (state == ST_GEO_GO) begin
      step_q <= geo_q;
      step_r <= geo_r;
    end
  end

  // advance frame, band and block position
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      band_idx   <= '0;
      blk_idx    <= '0;
      band_start <= '0;
      band_end   <= '0;
      blk_start  <= '0;
      blk_end    <= '0;
      qc         <= '0;
      qr         <= '0;
      rc         <= '0;
      rr         <= '0;
    end else if (restart) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      band_idx   <= '0;
      blk_idx    <= '0;
      band_start <= y0;
      band_end   <= y0 + geo_q;
      blk_start  <= x0;
      blk_end    <= x0 + geo_q;
      qc         <= geo_q;
      qr         <= geo_q;
      rc         <= geo_r;
      rr         <= geo_r;
    end else if (state == ST_ACC) begin
      if (in_crop && last_blk_col) begin
        if (blk_wrap) begin
          blk_idx   <= '0;
          blk_start <= x0;
          blk_end   <= x0 + step_q;
          qc        <= step_q;
          rc        <= step_r;
          if (last_band_row) begin
            if (band_wrap) begin
              band_idx   <= '0;
              band_start <= y0;
              band_end   <= y0 + step_q;
              qr         <= step_q;
              rr         <= step_r;
            end else begin
              band_idx   <= band_idx + 1'b1;
              band_start <= band_end;
              band_end   <= y0 + qr_adv;
              qr         <= qr_adv;
              rr         <= rr_adv;
            end
          end
        end else begin
          blk_idx   <= blk_idx + 1'b1;
          blk_start <= blk_end;
          blk_end   <= x0 + qc_adv;
          qc        <= qc_adv;
          rc        <= rc_adv;
        end
      end
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // latch the closing block's position
  always_ff @(posedge clk) begin
    if (state == ST_ACC && emit) begin
      em_col  <= blk_idx;
      em_row  <= band_idx;
      em_last <= (blk_idx == IDX_W'(OUT_SIDE - 1)) && (band_idx == IDX_W'(OUT_SIDE - 1));
      em_zero <= (cnt == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_SEND && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  logic [CH_W-1:0] mean [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mean[i] = em_zero ? '0 : div_quo[i][CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEND && (!m_tvalid || m_tready)) begin
      o_ch[0] <= quantize_565 ? quant5(mean[0]) : mean[0];
      o_ch[1] <= quantize_565 ? quant6(mean[1]) : mean[1];
      o_ch[2] <= quantize_565 ? quant5(mean[2]) : mean[2];
      o_col   <= em_col;
      o_row   <= em_row;
      o_last  <= em_last;
    end
  end

  assign m_tdata = {2'b00, COORD_W'(o_row), COORD_W'(o_col), o_ch[2], o_ch[1], o_ch[0]};
  assign m_tlast = o_last;

endmodule

[tb/tb.sv]
// Self-checking testbench of the centre-crop box downscaler: table and random pixels.
`timescale 1ns / 1ps

module tb;
  import ccbd_pkg::*;

  localparam int GRID       = 96;
  localparam int MAX_DIM    = 4096;
  localparam int SETTLE     = 300;
  localparam int CYCLE_STOP = 4000000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] column;
    logic [6:0] row;
    logic       last;
  } block_mean_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         typed;
    logic [7:0] exp_red;
    logic [7:0] exp_green;
    logic [7:0] exp_blue;
  } pixel_row_t;

  typedef struct {
    int unsigned width;
    int unsigned height;
    bit          quant;
    int          pixels;
    int          send_idle;
    int          recv_idle;
    bit          dummy_write;
  } frame_setup_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [39:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Predictor state
  int unsigned     geo_width;
  int unsigned     geo_height;
  bit              geo_quant;
  longint unsigned col_sum [GRID][3];
  int unsigned     src_col;
  int unsigned     src_row;
  int unsigned     band_idx;
  int unsigned     band_top;
  int unsigned     band_bottom;
  int unsigned     block_idx;
  int unsigned     block_left;
  int unsigned     block_right;

  block_mean_t pending_means[$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycles;

  center_crop_box_downscaler dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int unsigned clamp_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned square_side();
    int unsigned w;
    int unsigned h;
    w = clamp_dim(geo_width);
    h = clamp_dim(geo_height);
    return (w < h) ? w : h;
  endfunction

  function automatic int unsigned left_off();
    return (clamp_dim(geo_width) - square_side()) / 2;
  endfunction

  function automatic int unsigned top_off();
    return (clamp_dim(geo_height) - square_side()) / 2;
  endfunction

  function automatic int unsigned grid_edge(input int unsigned off, input int unsigned k);
    return off + (k * square_side()) / GRID;
  endfunction

  function automatic logic [7:0] to_565_five(input logic [7:0] v);
    return (v & 8'hf8) | (v >> 5);
  endfunction

  function automatic logic [7:0] to_565_six(input logic [7:0] v);
    return (v & 8'hfc) | (v >> 6);
  endfunction

  // Return to the start of a frame for the current geometry
  task automatic rewind_frame();
    for (int i = 0; i < GRID; i++) begin
      for (int c = 0; c < 3; c++) col_sum[i][c] = 0;
    end
    src_col     = 0;
    src_row     = 0;
    band_idx    = 0;
    band_top    = top_off();
    band_bottom = grid_edge(top_off(), 1);
    block_idx   = 0;
    block_left  = left_off();
    block_right = grid_edge(left_off(), 1);
  endtask

  // Accumulate one source pixel and queue the block mean it closes, if any
  task automatic downscale_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                 output bit closed);
    int unsigned     w;
    int unsigned     h;
    int unsigned     side;
    int unsigned     x0;
    int unsigned     y0;
    int unsigned     col;
    int unsigned     row;
    int unsigned     bi;
    longint unsigned area;
    block_mean_t     m;
    w      = clamp_dim(geo_width);
    h      = clamp_dim(geo_height);
    side   = square_side();
    x0     = left_off();
    y0     = top_off();
    col    = src_col;
    row    = src_row;
    closed = 1'b0;
    if (side >= GRID && col >= x0 && col < x0 + side && row >= y0 && row < y0 + side &&
        block_idx < GRID) begin
      bi = block_idx;
      col_sum[bi][0] += r;
      col_sum[bi][1] += g;
      col_sum[bi][2] += b;
      if (col + 1 >= block_right) begin
        if (row + 1 >= band_bottom) begin
          area    = longint'(block_right - block_left) * longint'(band_bottom - band_top);
          m.red   = (area != 0) ? 8'(col_sum[bi][0] / area) : 8'd0;
          m.green = (area != 0) ? 8'(col_sum[bi][1] / area) : 8'd0;
          m.blue  = (area != 0) ? 8'(col_sum[bi][2] / area) : 8'd0;
          if (geo_quant) begin
            m.red   = to_565_five(m.red);
            m.green = to_565_six(m.green);
            m.blue  = to_565_five(m.blue);
          end
          m.column = 7'(bi);
          m.row    = 7'(band_idx);
          m.last   = (bi == GRID - 1) && (band_idx == GRID - 1);
          pending_means.push_back(m);
          for (int c = 0; c < 3; c++) col_sum[bi][c] = 0;
          closed = 1'b1;
        end
        if (bi + 1 >= GRID) begin
          block_idx   = 0;
          block_left  = x0;
          block_right = grid_edge(x0, 1);
          if (row + 1 >= band_bottom) begin
            if (band_idx + 1 >= GRID) begin
              band_idx    = 0;
              band_top    = y0;
              band_bottom = grid_edge(y0, 1);
            end else begin
              band_idx++;
              band_top    = band_bottom;
              band_bottom = grid_edge(y0, band_idx + 1);
            end
          end
        end else begin
          block_idx   = bi + 1;
          block_left  = block_right;
          block_right = grid_edge(x0, block_idx + 1);
        end
      end
    end
    // Advance the raster position
    if (col + 1 >= w) begin
      src_col = 0;
      if (row + 1 >= h) rewind_frame();
      else src_row = row + 1;
    end else begin
      src_col = col + 1;
    end
  endtask

  // Offer one pixel word, with random gaps, and predict it once taken
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            output bit closed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    do @(posedge clk); while (!s_tready);
    downscale_pixel(r, g, b, closed);
  endtask

  task automatic drain_means();
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    s_tvalid <= 1'b0;
    drain_means();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:  geo_width  = val;
      REG_HEIGHT: geo_height = val;
      REG_QUANT:  geo_quant  = val[0];
      default:    return;
    endcase
    rewind_frame();
  endtask

  function automatic logic [7:0] random_level();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Take result words and compare them with the oldest predicted mean
  always @(posedge clk) begin
    block_mean_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_means.size() == 0) begin
          flag_mismatch("unexpected result word", 1, 0);
        end else begin
          want = pending_means.pop_front();
          if (m_tdata[7:0] !== want.red) flag_mismatch("red", m_tdata[7:0], want.red);
          if (m_tdata[15:8] !== want.green) flag_mismatch("green", m_tdata[15:8], want.green);
          if (m_tdata[23:16] !== want.blue) flag_mismatch("blue", m_tdata[23:16], want.blue);
          if (m_tdata[30:24] !== want.column)
            flag_mismatch("column", m_tdata[30:24], want.column);
          if (m_tdata[37:31] !== want.row) flag_mismatch("row", m_tdata[37:31], want.row);
          if (m_tlast !== want.last) flag_mismatch("frame_done", m_tlast, want.last);
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hold a hard limit on the run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_STOP) begin
      $display("[center_crop_box_downscaler] ERROR");
      $finish;
    end
  end

  initial begin
    pixel_row_t   pixel_rows[$];
    frame_setup_t setups[$];
    bit           closed;
    block_mean_t  typed_mean;

    cycles        = 0;
    mismatches    = 0;
    send_idle_pct = 33;
    recv_idle_pct = 77;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    geo_width  = 96;
    geo_height = 96;
    geo_quant  = 1'b1;
    rewind_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels on the reset geometry: every pixel is a block of its own
    pixel_rows = '{
      '{8'h00, 8'h00, 8'h00, 1, 8'h00, 8'h00, 8'h00},
      '{8'hff, 8'hff, 8'hff, 1, 8'hff, 8'hff, 8'hff},
      '{8'hff, 8'h00, 8'hff, 1, 8'hff, 8'h00, 8'hff},
      '{8'h00, 8'hff, 8'h00, 1, 8'h00, 8'hff, 8'h00},
      '{8'h08, 8'h04, 8'h08, 1, 8'h08, 8'h04, 8'h08},
      '{8'haa, 8'h55, 8'haa, 0, 8'h00, 8'h00, 8'h00},
      '{8'h55, 8'haa, 8'h55, 0, 8'h00, 8'h00, 8'h00},
      '{8'h07, 8'h03, 8'h07, 0, 8'h00, 8'h00, 8'h00},
      '{8'hf8, 8'hfc, 8'hf8, 0, 8'h00, 8'h00, 8'h00},
      '{8'h80, 8'h40, 8'h20, 0, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h02, 8'h04, 0, 8'h00, 8'h00, 8'h00},
      '{8'h7f, 8'hbf, 8'hdf, 0, 8'h00, 8'h00, 8'h00},
      '{8'h10, 8'h20, 8'h40, 0, 8'h00, 8'h00, 8'h00},
      '{8'hef, 8'hf7, 8'hfb, 0, 8'h00, 8'h00, 8'h00},
      '{8'h3c, 8'hc3, 8'h99, 0, 8'h00, 8'h00, 8'h00},
      '{8'h66, 8'h18, 8'he7, 0, 8'h00, 8'h00, 8'h00}
    };
    foreach (pixel_rows[i]) begin
      send_pixel(pixel_rows[i].red, pixel_rows[i].green, pixel_rows[i].blue, closed);
      if (pixel_rows[i].typed && closed) begin
        typed_mean       = pending_means.pop_back();
        typed_mean.red   = pixel_rows[i].exp_red;
        typed_mean.green = pixel_rows[i].exp_green;
        typed_mean.blue  = pixel_rows[i].exp_blue;
        pending_means.push_back(typed_mean);
      end
    end

    // Random phases over several geometries; the last phases run without gaps
    setups = '{
      '{96,   96,   1, 150, 33, 77, 0},
      '{100,  97,   0, 200, 33, 77, 0},
      '{200,  150,  1, 250, 33, 77, 1},
      '{0,    0,    1, 30,  77, 33, 0},
      '{8191, 96,   0, 150, 77, 33, 0},
      '{96,   100,  1, 200, 77, 33, 0},
      '{50,   4096, 0, 60,  77, 33, 0},
      '{96,   96,   0, 150, 0,  0,  1},
      '{4096, 4096, 1, 100, 0,  0,  0}
    };
    foreach (setups[p]) begin
      if (p != 0) begin
        write_reg(REG_WIDTH, CFG_W'(setups[p].width));
        write_reg(REG_HEIGHT, CFG_W'(setups[p].height));
        write_reg(REG_QUANT, CFG_W'(setups[p].quant));
        if (setups[p].dummy_write) write_reg(REG_UNUSED, CFG_W'($urandom));
      end
      send_idle_pct = setups[p].send_idle;
      recv_idle_pct = setups[p].recv_idle;
      for (int n = 0; n < setups[p].pixels; n++)
        send_pixel(random_level(), random_level(), random_level(), closed);
    end

    // Drain and finish
    s_tvalid <= 1'b0;
    drain_means();
    if (pending_means.size() != 0)
      flag_mismatch("missing result words", 0, pending_means.size());
    if (mismatches == 0) begin
      $display("[center_crop_box_downscaler] OK");
    end else begin
      $display("[center_crop_box_downscaler] ERROR");
    end
    $finish;
  end

endmodule
